// ===== rtl/fsp_pkg.sv =====
// shared constants, codes and record types of the fuel-state router
package fsp_pkg;

  localparam int MAX_CITIES  = 1024;
  localparam int MAX_ARCS    = 32768;
  localparam int FUEL_LEVELS = 128;
  localparam int HEAP_DEPTH  = 16384;

  localparam int OP_W     = 2;
  localparam int CITY_W   = $clog2(MAX_CITIES);
  localparam int AMT_W    = 8;
  localparam int CAP_W    = 7;
  localparam int COST_W   = 26;
  localparam int STATUS_W = 2;

  localparam int FUEL_W     = $clog2(FUEL_LEVELS);
  localparam int STATE_W    = CITY_W + FUEL_W;
  localparam int NUM_STATES = MAX_CITIES * FUEL_LEVELS;
  localparam int ARC_AW     = $clog2(MAX_ARCS);
  localparam int HEAP_AW    = $clog2(HEAP_DEPTH);
  localparam int FILL_W     = HEAP_AW + 1;
  localparam int EPOCH_W    = 8;
  localparam int CLR_W      = $clog2(NUM_STATES);

  localparam logic [OP_W-1:0] OP_PRICE = 2'd0;
  localparam logic [OP_W-1:0] OP_ROAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_REACHED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IMPOSSIBLE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 2'd2;

  localparam logic [COST_W-1:0] COST_ONES = '1;
  localparam logic [COST_W-1:0] COST_SAT  = COST_ONES - 1'b1;

  typedef struct packed {
    logic [COST_W-1:0]  cost;
    logic [STATE_W-1:0] st;
  } heap_key_t;

  typedef struct packed {
    logic [ARC_AW-1:0] link;
    logic [CITY_W-1:0] target;
    logic [AMT_W-1:0]  len;
  } arc_ent_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic               settled;
    logic [COST_W-1:0]  cost;
  } st_ent_t;

endpackage

// ===== rtl/fsp_if.sv =====
// valid/ready channel interfaces for request and result transactions
interface fsp_in_if;
  import fsp_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CITY_W-1:0] city_a;
  logic [CITY_W-1:0] city_b;
  logic [AMT_W-1:0]  amount;
  logic [CAP_W-1:0]  tank_capacity;
  modport source(output valid, op, city_a, city_b, amount, tank_capacity, input ready);
  modport sink(input valid, op, city_a, city_b, amount, tank_capacity, output ready);
endinterface

interface fsp_out_if;
  import fsp_pkg::*;
  logic                valid;
  logic                ready;
  logic [COST_W-1:0]   total_cost;
  logic [STATUS_W-1:0] status;
  modport source(output valid, total_cost, status, input ready);
  modport sink(input valid, total_cost, status, output ready);
endinterface

// ===== rtl/fsp_ram.sv =====
// generic single-write single-read ram with registered read data
module fsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fuel_state_shortest_path_core.sv =====
// cheapest-refuelling router: loader, heap engine and state search over memories
//
//  channel | dir | payload                                   | transaction
//  in_ch   | in  | op, city_a, city_b, amount, tank_capacity | price, road or query
//  out_ch  | out | total_cost, status                        | one per query
//
// price item: written as it is accepted. road item: head list read-then-write per arc end
// query: a setup step, then per pop a read of top and last entry and a sift-down, per
//   arc a list read and a state check, per push a sift-up; the single read port of
//   the heap memory sets the pace of sift-up and sift-down
// after reset a clearing pass sweeps all 131072 state memory entries and the list heads
// state entries carry an 8-bit query epoch; a query that finds the epoch at its top value
//   first runs the same sweep over state memory
// in_ch.ready is high only in idle; a finished result waits in the output register
//   while loads are taken, a later query holds at its end until out_ch drains
module fuel_state_shortest_path_core (
  input  logic         clk,
  input  logic         rst_n,
  fsp_in_if.sink       in_ch,
  fsp_out_if.source    out_ch
);
  import fsp_pkg::*;

  typedef enum logic [27:0] {
    S_CLEAR     = 28'h0000001,
    S_IDLE      = 28'h0000002,
    S_RD_A      = 28'h0000004,
    S_WR_A      = 28'h0000008,
    S_RD_B      = 28'h0000010,
    S_WR_B      = 28'h0000020,
    S_Q_START   = 28'h0000040,
    S_POP0      = 28'h0000080,
    S_POP1      = 28'h0000100,
    S_POP2      = 28'h0000200,
    S_SIFT      = 28'h0000400,
    S_SIFT_C1   = 28'h0000800,
    S_SIFT_C2   = 28'h0001000,
    S_SIFT_CMP  = 28'h0002000,
    S_PLACE     = 28'h0004000,
    S_ST_CHK    = 28'h0008000,
    S_BUY_RD    = 28'h0010000,
    S_BUY_CHK   = 28'h0020000,
    S_ARC_HEAD  = 28'h0040000,
    S_ARC_HEADW = 28'h0080000,
    S_ARC_CHECK = 28'h0100000,
    S_ARC_DATA  = 28'h0200000,
    S_ARC_UPD   = 28'h0400000,
    S_PUSH0     = 28'h0800000,
    S_PUSH_UP   = 28'h1000000,
    S_PUSH_CMP  = 28'h2000000,
    S_PUSH_W    = 28'h4000000,
    S_FIN       = 28'h8000000
  } fsm_t;

  // control and datapath registers
  fsm_t                state_r, state_nxt;
  fsm_t                ret_r, ret_nxt;           // return point after a push
  logic [CLR_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic                clr_head_r, clr_head_nxt; // sweep list heads too
  logic                clr_ret_r, clr_ret_nxt;   // sweep returns into a query
  logic [EPOCH_W-1:0]  epoch_r, epoch_nxt;
  logic [ARC_AW-1:0]   arc_total_r, arc_total_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [CITY_W-1:0]   ca_r, ca_nxt;
  logic [CITY_W-1:0]   cb_r, cb_nxt;
  logic [AMT_W-1:0]    amt_r, amt_nxt;
  logic [FUEL_W-1:0]   cap_r, cap_nxt;
  heap_key_t           top_r, top_nxt;
  heap_key_t           last_r, last_nxt;
  heap_key_t           hc_r, hc_nxt;
  heap_key_t           key_r, key_nxt;
  logic [HEAP_AW-1:0]  i_r, i_nxt;
  logic [HEAP_AW-1:0]  c_r, c_nxt;
  logic [COST_W-1:0]   cur_r, cur_nxt;
  logic [COST_W-1:0]   nc_r, nc_nxt;
  logic [AMT_W-1:0]    price_r, price_nxt;
  logic [STATE_W-1:0]  nst_r, nst_nxt;
  logic [ARC_AW-1:0]   a_r, a_nxt;
  logic [COST_W-1:0]   res_cost_r, res_cost_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [COST_W-1:0]   out_cost_r, out_cost_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  // memory ports
  logic                price_we;
  logic [CITY_W-1:0]   price_waddr, price_raddr;
  logic [AMT_W-1:0]    price_wdata, price_rdata;
  logic                head_we;
  logic [CITY_W-1:0]   head_waddr, head_raddr;
  logic [ARC_AW-1:0]   head_wdata, head_rdata;
  logic                arc_we;
  logic [ARC_AW-1:0]   arc_waddr, arc_raddr;
  arc_ent_t            arc_wdata, arc_rdata;
  logic                st_we;
  logic [STATE_W-1:0]  st_waddr, st_raddr;
  st_ent_t             st_wdata, st_rdata;
  logic                heap_we;
  logic [HEAP_AW-1:0]  heap_waddr, heap_raddr;
  heap_key_t           heap_wdata, heap_rdata;

  // derived values
  logic                in_acc;
  logic [CITY_W-1:0]   top_city;
  logic [FUEL_W-1:0]   top_fuel;
  logic                ent_valid, ent_settled;
  logic [COST_W-1:0]   ent_cost;
  logic [FILL_W-1:0]   c_full, c_next;
  logic [HEAP_AW-1:0]  up_idx;
  logic [COST_W:0]     buy_sum;
  logic [ARC_AW:0]     arc_room;
  logic [ARC_AW-1:0]   arc_new;

  fsp_ram #(.WIDTH(AMT_W), .DEPTH(MAX_CITIES)) u_price (
    .clk, .we(price_we), .waddr(price_waddr), .wdata(price_wdata),
    .raddr(price_raddr), .rdata(price_rdata)
  );
  fsp_ram #(.WIDTH(ARC_AW), .DEPTH(MAX_CITIES)) u_head (
    .clk, .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata)
  );
  fsp_ram #(.WIDTH($bits(arc_ent_t)), .DEPTH(MAX_ARCS)) u_arc (
    .clk, .we(arc_we), .waddr(arc_waddr), .wdata(arc_wdata),
    .raddr(arc_raddr), .rdata(arc_rdata)
  );
  fsp_ram #(.WIDTH($bits(st_ent_t)), .DEPTH(NUM_STATES)) u_state (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );
  fsp_ram #(.WIDTH($bits(heap_key_t)), .DEPTH(HEAP_DEPTH)) u_heap (
    .clk, .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
    .raddr(heap_raddr), .rdata(heap_rdata)
  );

  assign in_ch.ready       = (state_r == S_IDLE);
  assign in_acc            = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.total_cost = out_cost_r;
  assign out_ch.status     = out_status_r;

  assign top_city    = top_r.st[STATE_W-1:FUEL_W];
  assign top_fuel    = top_r.st[FUEL_W-1:0];
  // an entry from an older query reads as unreached and unsettled
  assign ent_valid   = (st_rdata.epoch == epoch_r);
  assign ent_settled = ent_valid && st_rdata.settled;
  assign ent_cost    = ent_valid ? st_rdata.cost : COST_ONES;
  assign c_full      = {i_r, 1'b1};
  assign c_next      = {1'b0, c_r} + 1'b1;
  assign up_idx      = HEAP_AW'((i_r - 1'b1) >> 1);
  assign buy_sum     = {1'b0, cur_r} + {{(COST_W + 1 - AMT_W){1'b0}}, price_r};
  assign arc_room    = {1'b0, arc_total_r} + 2'd2;
  assign arc_new     = arc_total_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_head_nxt   = clr_head_r;
    clr_ret_nxt    = clr_ret_r;
    epoch_nxt      = epoch_r;
    arc_total_nxt  = arc_total_r;
    fill_nxt       = fill_r;
    out_valid_nxt  = out_valid_r;
    ca_nxt         = ca_r;
    cb_nxt         = cb_r;
    amt_nxt        = amt_r;
    cap_nxt        = cap_r;
    top_nxt        = top_r;
    last_nxt       = last_r;
    hc_nxt         = hc_r;
    key_nxt        = key_r;
    i_nxt          = i_r;
    c_nxt          = c_r;
    cur_nxt        = cur_r;
    nc_nxt         = nc_r;
    price_nxt      = price_r;
    nst_nxt        = nst_r;
    a_nxt          = a_r;
    res_cost_nxt   = res_cost_r;
    res_status_nxt = res_status_r;
    out_cost_nxt   = out_cost_r;
    out_status_nxt = out_status_r;

    price_we    = 1'b0;
    price_waddr = in_ch.city_a;
    price_wdata = in_ch.amount;
    price_raddr = top_city;
    head_we     = 1'b0;
    head_waddr  = ca_r;
    head_wdata  = arc_new;
    head_raddr  = ca_r;
    arc_we      = 1'b0;
    arc_waddr   = arc_new;
    arc_wdata   = '{link: head_rdata, target: cb_r, len: amt_r};
    arc_raddr   = a_r;
    st_we       = 1'b0;
    st_waddr    = nst_r;
    st_wdata    = '{epoch: epoch_r, settled: 1'b0, cost: cur_r};
    st_raddr    = top_r.st;
    heap_we     = 1'b0;
    heap_waddr  = i_r;
    heap_wdata  = key_r;
    heap_raddr  = '0;

    // a consumer drains the output register at any time
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_cnt_r;
        st_wdata = '{epoch: '0, settled: 1'b0, cost: '0};
        if (clr_head_r && clr_cnt_r < CLR_W'(MAX_CITIES)) begin
          head_we    = 1'b1;
          head_waddr = clr_cnt_r[CITY_W-1:0];
          head_wdata = '0;
        end
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_W'(NUM_STATES - 1)) begin
          epoch_nxt = '0;
          state_nxt = clr_ret_r ? S_Q_START : S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          ca_nxt  = in_ch.city_a;
          cb_nxt  = in_ch.city_b;
          amt_nxt = in_ch.amount;
          cap_nxt = (in_ch.tank_capacity > CAP_W'(FUEL_LEVELS - 1)) ?
                    FUEL_W'(FUEL_LEVELS - 1) : FUEL_W'(in_ch.tank_capacity);
          case (in_ch.op)
            OP_PRICE: price_we = 1'b1;
            OP_ROAD: begin
              if (arc_room <= (ARC_AW + 1)'(MAX_ARCS - 1)) begin
                state_nxt = S_RD_A;
              end
            end
            OP_QUERY: state_nxt = S_Q_START;
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // road: link a new arc in front of each end's list
      S_RD_A: begin
        head_raddr = ca_r;
        state_nxt  = S_WR_A;
      end
      S_WR_A: begin
        arc_we        = 1'b1;
        arc_wdata     = '{link: head_rdata, target: cb_r, len: amt_r};
        head_we       = 1'b1;
        head_waddr    = ca_r;
        arc_total_nxt = arc_new;
        state_nxt     = S_RD_B;
      end
      S_RD_B: begin
        head_raddr = cb_r;
        state_nxt  = S_WR_B;
      end
      S_WR_B: begin
        arc_we        = 1'b1;
        arc_wdata     = '{link: head_rdata, target: ca_r, len: amt_r};
        head_we       = 1'b1;
        head_waddr    = cb_r;
        arc_total_nxt = arc_new;
        state_nxt     = S_IDLE;
      end

      // query setup: sweep if the epoch is at its top value, else new epoch, seed start state at cost zero
      S_Q_START: begin
        if (epoch_r == '1) begin
          clr_cnt_nxt  = '0;
          clr_head_nxt = 1'b0;
          clr_ret_nxt  = 1'b1;
          state_nxt    = S_CLEAR;
        end else begin
          epoch_nxt  = epoch_r + 1'b1;
          st_we      = 1'b1;
          st_waddr   = {ca_r, {FUEL_W{1'b0}}};
          st_wdata   = '{epoch: epoch_r + 1'b1, settled: 1'b0, cost: '0};
          heap_we    = 1'b1;
          heap_waddr = '0;
          heap_wdata = '{cost: '0, st: {ca_r, {FUEL_W{1'b0}}}};
          fill_nxt   = FILL_W'(1);
          state_nxt  = S_POP0;
        end
      end

      // pop: an empty heap ends the query as impossible, else top and last entry, then sift down
      S_POP0: begin
        if (fill_r == '0) begin
          res_cost_nxt   = '0;
          res_status_nxt = ST_IMPOSSIBLE;
          state_nxt      = S_FIN;
        end else begin
          heap_raddr = '0;
          state_nxt  = S_POP1;
        end
      end
      S_POP1: begin
        top_nxt    = heap_rdata;
        heap_raddr = HEAP_AW'(fill_r - 1'b1);
        fill_nxt   = fill_r - 1'b1;
        state_nxt  = S_POP2;
      end
      S_POP2: begin
        last_nxt  = heap_rdata;
        i_nxt     = '0;
        state_nxt = S_SIFT;
      end
      S_SIFT: begin
        if (c_full >= fill_r) begin
          state_nxt = S_PLACE;
        end else begin
          c_nxt      = c_full[HEAP_AW-1:0];
          heap_raddr = c_full[HEAP_AW-1:0];
          state_nxt  = S_SIFT_C1;
        end
      end
      S_SIFT_C1: begin
        hc_nxt = heap_rdata;
        if (c_next < fill_r) begin
          heap_raddr = c_next[HEAP_AW-1:0];
          state_nxt  = S_SIFT_C2;
        end else begin
          state_nxt = S_SIFT_CMP;
        end
      end
      S_SIFT_C2: begin
        // right child wins only when strictly smaller
        if (heap_rdata < hc_r) begin
          hc_nxt = heap_rdata;
          c_nxt  = c_next[HEAP_AW-1:0];
        end
        state_nxt = S_SIFT_CMP;
      end
      S_SIFT_CMP: begin
        if (last_r <= hc_r) begin
          state_nxt = S_PLACE;
        end else begin
          heap_we    = 1'b1;
          heap_waddr = i_r;
          heap_wdata = hc_r;
          i_nxt      = c_r;
          state_nxt  = S_SIFT;
        end
      end
      S_PLACE: begin
        if (fill_r != '0) begin
          heap_we    = 1'b1;
          heap_waddr = i_r;
          heap_wdata = last_r;
        end
        st_raddr    = top_r.st;
        price_raddr = top_city;
        state_nxt   = S_ST_CHK;
      end

      // settle the popped state
      S_ST_CHK: begin
        if (ent_settled) begin
          state_nxt = S_POP0;
        end else begin
          st_we     = 1'b1;
          st_waddr  = top_r.st;
          st_wdata  = '{epoch: epoch_r, settled: 1'b1, cost: ent_cost};
          cur_nxt   = ent_cost;
          price_nxt = price_rdata;
          if (top_city == cb_r) begin
            res_cost_nxt   = ent_cost;
            res_status_nxt = ST_REACHED;
            state_nxt      = S_FIN;
          end else if (top_fuel < cap_r) begin
            state_nxt = S_BUY_RD;
          end else begin
            state_nxt = S_ARC_HEAD;
          end
        end
      end

      // buy one fuel unit here
      S_BUY_RD: begin
        nst_nxt   = top_r.st + 1'b1;
        st_raddr  = top_r.st + 1'b1;
        nc_nxt    = (buy_sum > {1'b0, COST_SAT}) ? COST_SAT : buy_sum[COST_W-1:0];
        state_nxt = S_BUY_CHK;
      end
      S_BUY_CHK: begin
        if (!ent_settled && ent_cost > nc_r) begin
          st_we     = 1'b1;
          st_waddr  = nst_r;
          st_wdata  = '{epoch: epoch_r, settled: 1'b0, cost: nc_r};
          key_nxt   = '{cost: nc_r, st: nst_r};
          ret_nxt   = S_ARC_HEAD;
          state_nxt = S_PUSH0;
        end else begin
          state_nxt = S_ARC_HEAD;
        end
      end

      // walk the adjacency list of the current city
      S_ARC_HEAD: begin
        head_raddr = top_city;
        state_nxt  = S_ARC_HEADW;
      end
      S_ARC_HEADW: begin
        a_nxt     = head_rdata;
        state_nxt = S_ARC_CHECK;
      end
      S_ARC_CHECK: begin
        if (a_r == '0) begin
          state_nxt = S_POP0;
        end else begin
          arc_raddr = a_r;
          state_nxt = S_ARC_DATA;
        end
      end
      S_ARC_DATA: begin
        a_nxt = arc_rdata.link;
        if (arc_rdata.len > {1'b0, top_fuel}) begin
          state_nxt = S_ARC_CHECK;
        end else begin
          nst_nxt   = {arc_rdata.target, FUEL_W'({1'b0, top_fuel} - arc_rdata.len)};
          st_raddr  = {arc_rdata.target, FUEL_W'({1'b0, top_fuel} - arc_rdata.len)};
          state_nxt = S_ARC_UPD;
        end
      end
      S_ARC_UPD: begin
        if (!ent_settled && ent_cost > cur_r) begin
          st_we     = 1'b1;
          st_waddr  = nst_r;
          st_wdata  = '{epoch: epoch_r, settled: 1'b0, cost: cur_r};
          key_nxt   = '{cost: cur_r, st: nst_r};
          ret_nxt   = S_ARC_CHECK;
          state_nxt = S_PUSH0;
        end else begin
          state_nxt = S_ARC_CHECK;
        end
      end

      // push key_r: a full heap ends the query as overflow, else append at the end and sift up
      S_PUSH0: begin
        if (fill_r >= FILL_W'(HEAP_DEPTH)) begin
          res_cost_nxt   = '0;
          res_status_nxt = ST_OVERFLOW;
          state_nxt      = S_FIN;
        end else begin
          i_nxt     = fill_r[HEAP_AW-1:0];
          fill_nxt  = fill_r + 1'b1;
          state_nxt = S_PUSH_UP;
        end
      end
      S_PUSH_UP: begin
        if (i_r == '0) begin
          state_nxt = S_PUSH_W;
        end else begin
          heap_raddr = up_idx;
          state_nxt  = S_PUSH_CMP;
        end
      end
      S_PUSH_CMP: begin
        if (heap_rdata <= key_r) begin
          state_nxt = S_PUSH_W;
        end else begin
          heap_we    = 1'b1;
          heap_waddr = i_r;
          heap_wdata = heap_rdata;
          i_nxt      = up_idx;
          state_nxt  = S_PUSH_UP;
        end
      end
      S_PUSH_W: begin
        heap_we    = 1'b1;
        heap_waddr = i_r;
        heap_wdata = key_r;
        state_nxt  = ret_r;
      end

      // hand the result to the output register once it is free
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_cost_nxt   = res_cost_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ret_r       <= S_ARC_CHECK;
      clr_cnt_r   <= '0;
      clr_head_r  <= 1'b1;
      clr_ret_r   <= 1'b0;
      epoch_r     <= '0;
      arc_total_r <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_head_r  <= clr_head_nxt;
      clr_ret_r   <= clr_ret_nxt;
      epoch_r     <= epoch_nxt;
      arc_total_r <= arc_total_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    ca_r         <= ca_nxt;
    cb_r         <= cb_nxt;
    amt_r        <= amt_nxt;
    cap_r        <= cap_nxt;
    top_r        <= top_nxt;
    last_r       <= last_nxt;
    hc_r         <= hc_nxt;
    key_r        <= key_nxt;
    i_r          <= i_nxt;
    c_r          <= c_nxt;
    cur_r        <= cur_nxt;
    nc_r         <= nc_nxt;
    price_r      <= price_nxt;
    nst_r        <= nst_nxt;
    a_r          <= a_nxt;
    res_cost_r   <= res_cost_nxt;
    res_status_r <= res_status_nxt;
    out_cost_r   <= out_cost_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

// ===== rtl/fsp_checker.sv =====
// port-level checks for the fuel-state router, bound to the top level
module fsp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [fsp_pkg::OP_W-1:0]      in_op,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [fsp_pkg::COST_W-1:0]    out_total_cost,
  input logic [fsp_pkg::STATUS_W-1:0]  out_status
);
  import fsp_pkg::*;

  // clearing pass follows reset
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("ready right after reset");

  // a query leaves the block busy in the cycle after it is accepted
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_QUERY |=> !in_ready)
    else $error("ready right after query transaction");

  // cost is zero unless reached
  a_cost_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_REACHED |-> out_total_cost == '0)
    else $error("nonzero cost on failed query");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_total_cost) && $stable(out_status))
    else $error("result dropped or changed while stalled");

endmodule

bind fuel_state_shortest_path_core fsp_checker u_fsp_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .in_op(in_ch.op),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_total_cost(out_ch.total_cost),
  .out_status(out_ch.status)
);

// ===== tb/fuel_state_shortest_path_checker.sv =====
// transaction monitor, route-cost predictor and result comparison for the fuel-state router
`timescale 1ns / 1ps
module fuel_state_shortest_path_checker
  import fsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  fsp_in_if         in_mon,
  fsp_out_if        out_mon,
  output int        fail_count,
  output int        routes_waiting,
  output int        routes_reached
);

  typedef struct {
    logic [COST_W-1:0]   cost;
    logic [STATUS_W-1:0] status;
  } route_result_t;

  route_result_t expected_routes[$];

  logic [AMT_W-1:0]  fuel_price[MAX_CITIES];
  int unsigned       road_head[MAX_CITIES];
  int unsigned       road_link[MAX_ARCS];
  int unsigned       road_dest[MAX_ARCS];
  logic [AMT_W-1:0]  road_len[MAX_ARCS];
  int unsigned       road_count;

  heap_key_t         frontier[HEAP_DEPTH];
  int unsigned       frontier_fill;
  int unsigned       cheapest[int unsigned];
  bit                done_state[int unsigned];

  assign routes_waiting = expected_routes.size();

  function automatic bit frontier_insert(heap_key_t k);
    int unsigned i, up;
    if (frontier_fill >= HEAP_DEPTH) return 1'b0;
    i = frontier_fill;
    frontier_fill++;
    while (i > 0) begin
      up = (i - 1) / 2;
      if (frontier[up] <= k) break;
      frontier[i] = frontier[up];
      i = up;
    end
    frontier[i] = k;
    return 1'b1;
  endfunction

  function automatic heap_key_t frontier_take();
    heap_key_t top, last;
    int unsigned i, c;
    top = frontier[0];
    frontier_fill--;
    last = frontier[frontier_fill];
    i = 0;
    forever begin
      c = 2 * i + 1;
      if (c >= frontier_fill) break;
      if (c + 1 < frontier_fill && frontier[c+1] < frontier[c]) c++;
      if (last <= frontier[c]) break;
      frontier[i] = frontier[c];
      i = c;
    end
    if (frontier_fill > 0) frontier[i] = last;
    return top;
  endfunction

  function automatic int unsigned cost_of(int unsigned st);
    return cheapest.exists(st) ? cheapest[st] : int'(COST_ONES);
  endfunction

  function automatic bit is_done(int unsigned st);
    return done_state.exists(st) ? done_state[st] : 1'b0;
  endfunction

  // lazy search over (city, fuel) states; returns 0 when the frontier overflows
  function automatic bit relax(int unsigned nst, int unsigned nc);
    heap_key_t k;
    if (!is_done(nst) && cost_of(nst) > nc) begin
      cheapest[nst] = nc;
      k.cost = nc[COST_W-1:0];
      k.st   = nst[STATE_W-1:0];
      return frontier_insert(k);
    end
    return 1'b1;
  endfunction

  function automatic route_result_t predict_route(int unsigned start, int unsigned goal,
                                                  int unsigned cap);
    route_result_t r;
    heap_key_t k;
    int unsigned st, city, fuel, cur, nc, a;
    r.cost = '0;
    r.status = ST_IMPOSSIBLE;
    cheapest.delete();
    done_state.delete();
    frontier_fill = 0;
    if (cap > FUEL_LEVELS - 1) cap = FUEL_LEVELS - 1;
    cheapest[start * FUEL_LEVELS] = 0;
    k.cost = '0;
    k.st = STATE_W'(start * FUEL_LEVELS);
    void'(frontier_insert(k));
    while (frontier_fill > 0) begin
      k = frontier_take();
      st = k.st;
      if (is_done(st)) continue;
      done_state[st] = 1'b1;
      city = st / FUEL_LEVELS;
      fuel = st % FUEL_LEVELS;
      cur = cost_of(st);
      if (city == goal) begin
        r.cost = cur[COST_W-1:0];
        r.status = ST_REACHED;
        return r;
      end
      if (fuel < cap) begin
        nc = cur + fuel_price[city];
        if (nc > COST_SAT) nc = COST_SAT;
        if (!relax(st + 1, nc)) begin
          r.status = ST_OVERFLOW;
          return r;
        end
      end
      for (a = road_head[city]; a != 0 && a < MAX_ARCS; a = road_link[a]) begin
        if (road_len[a] > fuel) continue;
        if (!relax(road_dest[a] * FUEL_LEVELS + (fuel - road_len[a]), cur)) begin
          r.status = ST_OVERFLOW;
          return r;
        end
      end
    end
    return r;
  endfunction

  function automatic void add_arc(int unsigned from, int unsigned to, logic [AMT_W-1:0] len);
    road_count++;
    road_link[road_count] = road_head[from];
    road_dest[road_count] = to;
    road_len[road_count]  = len;
    road_head[from] = road_count;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    routes_reached = 0;
    road_count = 0;
    frontier_fill = 0;
    foreach (road_head[i]) road_head[i] = 0;
  end

  always @(posedge clk) begin
    route_result_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.op)
          OP_PRICE: fuel_price[in_mon.city_a] = in_mon.amount;
          OP_ROAD: begin
            if (road_count + 2 <= MAX_ARCS - 1) begin
              add_arc(in_mon.city_a, in_mon.city_b, in_mon.amount);
              add_arc(in_mon.city_b, in_mon.city_a, in_mon.amount);
            end
          end
          OP_QUERY: expected_routes.push_back(
            predict_route(in_mon.city_a, in_mon.city_b, in_mon.tank_capacity));
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_routes.size() == 0) begin
          report_mismatch("unexpected result, status", out_mon.status, 0);
        end else begin
          want = expected_routes.pop_front();
          if (out_mon.status != want.status)
            report_mismatch("status", out_mon.status, want.status);
          if (out_mon.total_cost != want.cost)
            report_mismatch("total_cost", out_mon.total_cost, want.cost);
          if (want.status == ST_REACHED) routes_reached++;
        end
      end
    end
  end

endmodule

// ===== tb/fuel_state_shortest_path_core_tb.sv =====
// stimulus, handshake pacing and verdict for the fuel-state router regression
`timescale 1ns / 1ps
module fuel_state_shortest_path_core_tb;
  import fsp_pkg::*;

  logic clk;
  logic rst_n;
  fsp_in_if  in_ch();
  fsp_out_if out_ch();

  int fail_count;
  int routes_waiting;
  int routes_reached;

  // pacing knobs of the sender and the receiver, send counts and the city pool
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_cycles;
  int items_sent;
  int queries_sent;
  int city_pool[$];

  fuel_state_shortest_path_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fuel_state_shortest_path_checker route_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .fail_count     (fail_count),
    .routes_waiting (routes_waiting),
    .routes_reached (routes_reached)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls, or one long hold-off counted here so the block backs up
  always @(posedge clk) begin
    if (rx_hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold_cycles <= rx_hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // one request transaction; the valid stays high into the next item unless a gap is drawn
  task automatic send_item(logic [OP_W-1:0] op, int unsigned a, int unsigned b,
                           int unsigned amt, int unsigned cap);
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.city_a        <= CITY_W'(a);
    in_ch.city_b        <= CITY_W'(b);
    in_ch.amount        <= AMT_W'(amt);
    in_ch.tank_capacity <= CAP_W'(cap);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (op == OP_QUERY) queries_sent++;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic int unsigned pick_city();
    return city_pool[$urandom_range(0, city_pool.size() - 1)];
  endfunction

  // road lengths and tank sizes stay mostly small so each search touches few states
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 10) return $urandom_range(0, 255);
    return $urandom_range(1, 3);
  endfunction

  function automatic int unsigned pick_capacity();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 4);
    return $urandom_range(5, 9);
  endfunction

  initial begin
    int unsigned r;
    int n;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_PRICE;
    in_ch.city_a = '0;
    in_ch.city_b = '0;
    in_ch.amount = '0;
    in_ch.tank_capacity = '0;
    out_ch.ready = 1'b0;
    rx_hold_cycles = 0;
    items_sent = 0;
    queries_sent = 0;
    tx_idle_pct = 32;
    rx_idle_pct = 68;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extreme cities, prices and lengths on a tiny graph
    send_item(OP_PRICE, 0, 0, 255, 0);
    send_item(OP_PRICE, 1023, 0, 0, 0);
    send_item(OP_PRICE, 341, 0, 1, 0);
    send_item(OP_PRICE, 682, 0, 128, 0);
    send_item(OP_QUERY, 0, 0, 0, 0);          // goal is the start city
    send_item(OP_QUERY, 0, 1023, 0, 0);       // no roads yet
    send_item(OP_ROAD, 0, 1023, 255, 0);      // longer than any tank
    send_item(OP_QUERY, 0, 1023, 0, 127);     // full tank still too short
    send_item(OP_ROAD, 0, 341, 1, 0);
    send_item(OP_ROAD, 341, 682, 0, 0);       // free road
    send_item(OP_ROAD, 682, 1023, 127, 0);
    send_item(OP_QUERY, 0, 682, 0, 0);        // empty tank, cannot move
    send_item(OP_QUERY, 0, 682, 0, 1);
    send_item(OP_QUERY, 341, 1023, 0, 127);
    send_item(OP_QUERY, 1023, 0, 255, 3);
    send_item(2'd3, 1023, 1023, 255, 127);    // unused opcode
    send_item(2'd3, 0, 0, 0, 0);
    send_item(OP_ROAD, 0, 0, 2, 0);           // self loop
    send_item(OP_QUERY, 682, 0, 0, 2);
    send_item(OP_QUERY, 0, 1023, 0, 127);

    // random part: a priced pool of cities, then mixed loads and queries
    city_pool = '{0, 341, 682, 1023};
    repeat (30) city_pool.push_back($urandom_range(0, 1023));
    for (n = 4; n < city_pool.size(); n++)
      send_item(OP_PRICE, city_pool[n], 0, $urandom_range(0, 255), 0);

    while (items_sent < 400) begin
      if (items_sent >= 160) tx_idle_pct = (items_sent >= 290) ? 0 : 68;
      if (items_sent >= 160) rx_idle_pct = (items_sent >= 290) ? 0 : 32;
      if (items_sent == 230) rx_hold_cycles <= 20000;
      if (items_sent == 320) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (routes_waiting != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 20)
        send_item(OP_PRICE, pick_city(), $urandom_range(0, 1023), $urandom_range(0, 255),
                  $urandom_range(0, 127));
      else if (r < 55)
        send_item(OP_ROAD, pick_city(), pick_city(), pick_length(), $urandom_range(0, 127));
      else if (r < 92)
        send_item(OP_QUERY, pick_city(), pick_city(), $urandom_range(0, 255),
                  pick_capacity());
      else
        send_item(2'd3, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 255), $urandom_range(0, 127));
    end
    in_ch.valid <= 1'b0;

    while (routes_waiting != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("sent %0d transactions, %0d of them route queries, %0d routes reached",
             items_sent, queries_sent, routes_reached);
    if (fail_count == 0) begin
      $display("fuel_state_shortest_path_core regression: pass");
    end else begin
      $display("fuel_state_shortest_path_core regression: fail");
    end
    $finish;
  end

  // watchdog covers the post-reset sweep and slow searches many times over
  initial begin
    #400_000_000;
    $display("fuel_state_shortest_path_core regression: fail");
    $finish;
  end

endmodule
